FILE: rtl/hsmt_pkg.sv
// Package for the hashed segment memo table: codes, hash constants and the
// command and status structs between controller and datapath. No dependencies.
package hsmt_pkg;

  // FNV-1a 64 constants. The prime is 2^40 + 0x1B3.
  localparam logic [63:0] HASH_BASIS  = 64'hCBF29CE484222325;
  localparam int          PRIME_SHIFT = 40;
  localparam logic [8:0]  PRIME_LO    = 9'h1B3;

  localparam logic [15:0] USE_MAX   = 16'hFFFF;
  localparam logic [31:0] TOTAL_MAX = 32'hFFFFFFFF;

  // Field widths fixed by the item format.
  localparam int SEG_W      = 11;
  localparam int MAXE_W     = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int LIM_W      = 13;
  localparam int SEGM_W     = 17;

  // Operation codes.
  localparam logic [1:0] OP_ABSORB = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_STORE  = 2'd2;

  // Outcome codes.
  localparam logic [2:0] OUT_ABSORBED = 3'd0;
  localparam logic [2:0] OUT_HIT      = 3'd1;
  localparam logic [2:0] OUT_MISS     = 3'd2;
  localparam logic [2:0] OUT_SHORT    = 3'd3;
  localparam logic [2:0] OUT_STORED   = 3'd4;
  localparam logic [2:0] OUT_PRESENT  = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SEG_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ENT = 1'b1;

  typedef struct packed {
    logic       capture;
    logic       fold;
    logic [1:0] round;
    logic       close;
    logic       scan_init;
    logic       scan_cmp;
    logic       hit;
    logic       miss;
    logic       insert;
    logic       load_out;
    logic [2:0] outcome;
  } hsmt_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       room;
    logic       full;
    logic       scan_last;
    logic       found;
    logic       out_busy;
  } hsmt_sts_t;

endpackage

FILE: rtl/hsmt_in_if.sv
// Input channel of the memo table: valid, ready and one traced item.
// Depends on nothing.
interface hsmt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [4:0]  type_flags;
  logic [63:0] address;
  logic [15:0] access_size;
  logic [7:0]  thread;
  logic [63:0] state_hash;
  logic [63:0] payload_in;

  modport source (output valid, op, type_flags, address, access_size, thread,
                  state_hash, payload_in, input ready);
  modport sink (input valid, op, type_flags, address, access_size, thread,
                state_hash, payload_in, output ready);
endinterface

FILE: rtl/hsmt_out_if.sv
// Result channel of the memo table: valid, ready and one result item.
// Depends on nothing.
interface hsmt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  outcome;
  logic [63:0] payload_out;
  logic [15:0] use_count;
  logic [31:0] hit_total;
  logic [31:0] miss_total;

  modport source (output valid, outcome, payload_out, use_count, hit_total,
                  miss_total, input ready);
  modport sink (input valid, outcome, payload_out, use_count, hit_total,
                miss_total, output ready);
endinterface

FILE: rtl/hsmt_cfg_if.sv
// Configuration write channel of the memo table: valid, ready, index, data.
// Depends on nothing.
interface hsmt_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [10:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/hsmt_ctrl.sv
// Controller of the memo table: sequences hashing, table scan and result.
// Depends on hsmt_pkg.
module hsmt_ctrl
  import hsmt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  hsmt_sts_t sts,
  output hsmt_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_FOLD, S_SCAN_RD, S_SCAN_CMP, S_RESOLVE, S_DONE
  } state_t;

  state_t     state_r;
  logic [1:0] round_r;
  logic [2:0] outcome_r;
  logic       is_close;

  assign is_close = (sts.op == OP_LOOKUP) || (sts.op == OP_STORE);
  assign in_ready = (state_r == S_IDLE);

  // Commands decoded from the current state.
  always_comb begin
    cmd = '0;
    cmd.round = round_r;
    cmd.outcome = outcome_r;
    case (state_r)
      S_IDLE: cmd.capture = in_valid;
      S_DECIDE: begin
        cmd.close = is_close;
        cmd.scan_init = is_close && sts.full;
      end
      S_FOLD: cmd.fold = 1'b1;
      S_SCAN_CMP: cmd.scan_cmp = 1'b1;
      S_RESOLVE: begin
        if (sts.op == OP_LOOKUP) begin
          cmd.hit = sts.found;
          cmd.miss = !sts.found;
        end else begin
          cmd.insert = !sts.found;
        end
      end
      S_DONE: cmd.load_out = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

  // State and registered outcome.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      round_r <= 2'd0;
      outcome_r <= OUT_ABSORBED;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          round_r <= 2'd0;
          outcome_r <= OUT_ABSORBED;
          if (sts.op == OP_ABSORB && sts.room) begin
            state_r <= S_FOLD;
          end else if (is_close && sts.full) begin
            state_r <= S_SCAN_RD;
          end else begin
            if (is_close) outcome_r <= OUT_SHORT;
            state_r <= S_DONE;
          end
        end
        S_FOLD: begin
          round_r <= round_r + 2'd1;
          if (round_r == 2'd3) state_r <= S_DONE;
        end
        S_SCAN_RD: state_r <= S_SCAN_CMP;
        S_SCAN_CMP: state_r <= sts.scan_last ? S_RESOLVE : S_SCAN_RD;
        S_RESOLVE: begin
          if (sts.op == OP_LOOKUP) outcome_r <= sts.found ? OUT_HIT : OUT_MISS;
          else outcome_r <= sts.found ? OUT_PRESENT : OUT_STORED;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!sts.out_busy) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/hsmt_dp.sv
// Datapath of the memo table: hash rounds, entry memories, scan and counters.
// Depends on hsmt_pkg; driven by hsmt_ctrl.
module hsmt_dp
  import hsmt_pkg::*;
#(
  parameter int ENTRIES      = 64,
  parameter int SEGMENT_MAX  = 1024,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hsmt_cmd_t             cmd,
  output hsmt_sts_t             sts,
  input  logic [1:0]            op,
  input  logic [4:0]            type_flags,
  input  logic [63:0]           address,
  input  logic [15:0]           access_size,
  input  logic [7:0]            thread,
  input  logic [63:0]           state_hash,
  input  logic [63:0]           payload_in,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [2:0]            outcome,
  output logic [63:0]           payload_out,
  output logic [15:0]           use_count,
  output logic [31:0]           hit_total,
  output logic [31:0]           miss_total
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  // Configuration and captured item.
  logic [SEG_W-1:0]  seg_len_r;
  logic [MAXE_W-1:0] max_ent_r;
  logic [1:0]        op_r;
  logic [4:0]        flags_r;
  logic [63:0]       addr_r, sk_r;
  logic [15:0]       size_r;
  logic [7:0]        thread_r;
  logic [PAYLOAD_BITS-1:0] pay_in_r;

  // Hash state and totals.
  logic [63:0]      acc_r, pk_r;
  logic [SEG_W-1:0] events_r;
  logic [31:0]      clock_r, hits_r, misses_r;

  // Entry storage.
  logic [63:0]             mem_pk [ENTRIES];
  logic [63:0]             mem_sk [ENTRIES];
  logic [PAYLOAD_BITS-1:0] mem_pay [ENTRIES];
  logic [15:0]             mem_use [ENTRIES];
  logic [31:0]             mem_stamp [ENTRIES];
  logic [ENTRIES-1:0]      valid_r;
  logic [63:0]             rd_pk_r, rd_sk_r;
  logic [PAYLOAD_BITS-1:0] rd_pay_r;
  logic [15:0]             rd_use_r;
  logic [31:0]             rd_stamp_r;

  // Scan results.
  logic [IW-1:0]           idx_r, match_idx_r, pick_idx_r, free_idx_r, slot;
  logic                    found_r, pick_found_r, free_found_r;
  logic [CW-1:0]           count_r;
  logic [31:0]             best_age_r, age;
  logic [PAYLOAD_BITS-1:0] match_pay_r;
  logic [15:0]             match_use_r, use_inc, res_use_r;
  logic [63:0]             res_pay_r;
  logic                    evict;

  // Effective segment length and occupancy limit.
  logic [SEGM_W-1:0] eff_len;
  logic [LIM_W-1:0]  lim, lim_m;

  assign eff_len = (SEGM_W'(seg_len_r) > SEGM_W'(SEGMENT_MAX)) ? SEGM_W'(SEGMENT_MAX)
                                                                : SEGM_W'(seg_len_r);
  assign lim_m = (max_ent_r == '0) ? LIM_W'(1) : LIM_W'(max_ent_r);
  assign lim = (lim_m > LIM_W'(ENTRIES)) ? LIM_W'(ENTRIES) : lim_m;

  // One hash round: xor, then multiply by 2^40 + 0x1B3.
  logic [63:0] word, x, h_nxt;
  always_comb begin
    case (cmd.round)
      2'd0: word = 64'(flags_r);
      2'd1: word = addr_r;
      2'd2: word = 64'(size_r);
      2'd3: word = 64'(thread_r);
      default: word = '0;
    endcase
    x = acc_r ^ word;
    h_nxt = (x << PRIME_SHIFT) + 64'(x * PRIME_LO);
  end

  assign age = clock_r - rd_stamp_r;
  assign use_inc = (match_use_r == USE_MAX) ? USE_MAX : match_use_r + 16'd1;
  assign evict = (LIM_W'(count_r) >= lim);
  assign slot = (evict && !(free_found_r && free_idx_r < pick_idx_r)) ? pick_idx_r
                                                                        : free_idx_r;

  assign sts.op = op_r;
  assign sts.room = (SEGM_W'(events_r) < eff_len);
  assign sts.full = (SEGM_W'(events_r) >= eff_len);
  assign sts.scan_last = (idx_r == IW'(ENTRIES - 1));
  assign sts.found = found_r;
  assign sts.out_busy = out_valid && !out_ready;

  // Entry memories with registered reads.
  always_ff @(posedge clk) begin
    rd_pk_r <= mem_pk[idx_r];
    rd_sk_r <= mem_sk[idx_r];
    rd_pay_r <= mem_pay[idx_r];
    rd_use_r <= mem_use[idx_r];
    rd_stamp_r <= mem_stamp[idx_r];
    if (cmd.hit) mem_use[match_idx_r] <= use_inc;
    if (cmd.insert) begin
      mem_pk[slot] <= pk_r;
      mem_sk[slot] <= sk_r;
      mem_pay[slot] <= pay_in_r;
      mem_use[slot] <= 16'd0;
      mem_stamp[slot] <= clock_r + 32'd1;
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      flags_r <= type_flags;
      addr_r <= address;
      size_r <= access_size;
      thread_r <= thread;
      sk_r <= state_hash;
      pay_in_r <= payload_in[PAYLOAD_BITS-1:0];
      res_pay_r <= '0;
      res_use_r <= '0;
    end
    if (cmd.close) pk_r <= acc_r;
    if (cmd.scan_cmp && valid_r[idx_r]) begin
      if (!found_r && rd_pk_r == pk_r && rd_sk_r == sk_r) begin
        match_idx_r <= idx_r;
        match_pay_r <= rd_pay_r;
        match_use_r <= rd_use_r;
      end
      if (!pick_found_r || age > best_age_r) begin
        pick_idx_r <= idx_r;
        best_age_r <= age;
      end
    end
    if (cmd.scan_cmp && !valid_r[idx_r] && !free_found_r) free_idx_r <= idx_r;
    if (cmd.hit) begin
      res_pay_r <= 64'(match_pay_r);
      res_use_r <= use_inc;
    end
    if (cmd.load_out) begin
      outcome <= cmd.outcome;
      payload_out <= res_pay_r;
      use_count <= res_use_r;
      hit_total <= hits_r;
      miss_total <= misses_r;
    end
  end

  // Control state, counters and valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_len_r <= SEG_W'(8);
      max_ent_r <= MAXE_W'(64);
      op_r <= OP_ABSORB;
      acc_r <= HASH_BASIS;
      events_r <= '0;
      clock_r <= '0;
      hits_r <= '0;
      misses_r <= '0;
      valid_r <= '0;
      idx_r <= '0;
      found_r <= 1'b0;
      pick_found_r <= 1'b0;
      free_found_r <= 1'b0;
      count_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SEG_LEN: seg_len_r <= cfg_data[SEG_W-1:0];
          REG_MAX_ENT: max_ent_r <= cfg_data[MAXE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.capture) op_r <= op;
      if (cmd.fold) begin
        acc_r <= h_nxt;
        if (cmd.round == 2'd3) events_r <= events_r + SEG_W'(1);
      end
      if (cmd.close) begin
        acc_r <= HASH_BASIS;
        events_r <= '0;
      end
      if (cmd.scan_init) begin
        idx_r <= '0;
        found_r <= 1'b0;
        pick_found_r <= 1'b0;
        free_found_r <= 1'b0;
        count_r <= '0;
      end
      if (cmd.scan_cmp) begin
        if (!sts.scan_last) idx_r <= idx_r + IW'(1);
        if (valid_r[idx_r]) begin
          count_r <= count_r + CW'(1);
          pick_found_r <= 1'b1;
          if (rd_pk_r == pk_r && rd_sk_r == sk_r) found_r <= 1'b1;
        end else begin
          free_found_r <= 1'b1;
        end
      end
      if (cmd.hit && hits_r != TOTAL_MAX) hits_r <= hits_r + 32'd1;
      if (cmd.miss && misses_r != TOTAL_MAX) misses_r <= misses_r + 32'd1;
      if (cmd.insert) begin
        clock_r <= clock_r + 32'd1;
        valid_r[slot] <= 1'b1;
        if (evict && slot != pick_idx_r) valid_r[pick_idx_r] <= 1'b0;
      end
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // A hit is only taken on an entry that the scan matched.
  a_hit_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hit |-> found_r)
    else $error("hit without a matching entry");

  // An inserted slot is valid afterwards.
  a_insert_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |=> valid_r[$past(slot)])
    else $error("inserted slot not valid");

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid && !out_ready))
    else $error("result overwritten");

  // An insert never raises the occupancy above the valid entries the scan counted, plus one.
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |=> ($countones(valid_r) <= $past(32'(count_r)) + 1))
    else $error("occupancy grew by more than one");

endmodule

FILE: rtl/hashed_segment_memo_table.sv
// Hashed segment memo table: FNV-1a 64 segment hash keyed into a FIFO memo.
// Path to result: a folded event runs its 4 hash rounds, one per cycle; a short close,
// an excess event or the unused op goes straight to the result; a full lookup or store
// first scans every entry of the entry memory, reading and then comparing each one.
// One item is in work at a time; the next input is taken once the result is loaded.
// Reset (rst_n low, synchronous) clears all valid bits, counters and the hash.
module hashed_segment_memo_table
  import hsmt_pkg::*;
#(
  parameter int ENTRIES      = 64,
  parameter int SEGMENT_MAX  = 1024,
  parameter int PAYLOAD_BITS = 64
) (
  input logic        clk,
  input logic        rst_n,
  hsmt_in_if.sink    in_ch,
  hsmt_out_if.source out_ch,
  hsmt_cfg_if.sink   cfg_ch
);

  hsmt_cmd_t cmd;
  hsmt_sts_t sts;

  // Configuration writes are always taken.
  assign cfg_ch.ready = 1'b1;

  hsmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hsmt_dp #(
    .ENTRIES      (ENTRIES),
    .SEGMENT_MAX  (SEGMENT_MAX),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .op          (in_ch.op),
    .type_flags  (in_ch.type_flags),
    .address     (in_ch.address),
    .access_size (in_ch.access_size),
    .thread      (in_ch.thread),
    .state_hash  (in_ch.state_hash),
    .payload_in  (in_ch.payload_in),
    .cfg_we      (cfg_ch.valid),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .outcome     (out_ch.outcome),
    .payload_out (out_ch.payload_out),
    .use_count   (out_ch.use_count),
    .hit_total   (out_ch.hit_total),
    .miss_total  (out_ch.miss_total)
  );

endmodule
